[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each module that uses them has clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/frp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types, constants and the command length table of the frame parser.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h02;

  localparam logic [7:0] CMD_S = 8'h53;
  localparam logic [7:0] CMD_L = 8'h4C;
  localparam logic [7:0] CMD_R = 8'h52;
  localparam logic [7:0] CMD_T = 8'h54;
  localparam logic [7:0] CMD_C = 8'h43;
  localparam logic [7:0] CMD_Z = 8'h5A;
  localparam logic [7:0] CMD_D = 8'h44;

  localparam int CNT_W       = 6;
  localparam int IDX_W       = 5;
  localparam int LEN_W       = 5;
  localparam int STORE_DEPTH = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LEN_W-1:0] LEN_SHORT = 5'd2;
  localparam logic [LEN_W-1:0] LEN_MID   = 5'd10;
  localparam logic [LEN_W-1:0] LEN_C     = 5'd11;
  localparam logic [LEN_W-1:0] LEN_Z     = 5'd6;
  localparam logic [LEN_W-1:0] LEN_T     = 5'd22;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_GOOD = 2'd1,
    ST_CSUM = 2'd2,
    ST_OVFL = 2'd3
  } status_t;

  // One entry of the queue: a status result or a good frame to replay.
  typedef struct packed {
    status_t          status;
    logic [7:0]       addr;
    logic [7:0]       cmd;
    logic [LEN_W-1:0] len;
  } job_t;

  // Data store write port, front to back.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  function automatic logic [LEN_W-1:0] len_for_command(input logic [7:0] c);
    logic [LEN_W-1:0] n;
    case (c) inside
      CMD_S, CMD_D: n = LEN_SHORT;
      CMD_L, CMD_R: n = LEN_MID;
      CMD_T:        n = LEN_T;
      CMD_C:        n = LEN_C;
      CMD_Z:        n = LEN_Z;
      default:      n = '0;
    endcase
    return n;
  endfunction

endpackage

[rtl/frp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_if
// Valid/ready channels: received bytes in, parser results out.
// ----------------------------------------------------------------------------
interface frp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface frp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] node_addr;
  logic [7:0] command;
  logic [4:0] data_count;
  logic [4:0] data_index;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output status, output node_addr, output command,
                  output data_count, output data_index, output data_byte, output last,
                  input ready);
  modport sink (input valid, input status, input node_addr, input command,
                input data_count, input data_index, input data_byte, input last,
                output ready);
endinterface

[rtl/frp_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_fifo
// Small job queue between the parser front and the result back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frp_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frp_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output frp_pkg::job_t dout,
  output logic          not_empty
);

  localparam int DEPTH = frp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frp_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign dout      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMP(a_fifo_bound, 1'b1, count <= CNT_W'(DEPTH), "job queue count out of range")
  `ASSERT_IMP(a_no_overflow, push, !full, "job queue overflow")
  `ASSERT_IMP(a_no_underflow, pop, not_empty, "job queue underflow")

endmodule

[rtl/frp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_front
// Frame parser: hunts sync, tracks header, data and checksum, writes data
// bytes to the store and queues one job per accepted byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frp_front #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic                clk,
  input  logic                rst,
  frp_in_if.sink              in,
  input  logic                run_done,
  output logic                q_push,
  output frp_pkg::job_t       q_job,
  input  logic                q_full,
  output frp_pkg::store_wr_t  store_wr
);

  localparam int CW = frp_pkg::CNT_W;
  localparam logic [CW-1:0] LIMIT = CW'(MAX_FRAME);
  localparam logic [CW-1:0] HDR   = CW'(4);

  typedef enum logic [2:0] {
    PH_SYNC, PH_AHI, PH_ALO, PH_CMD, PH_DATA, PH_CSUM
  } phase_t;

  phase_t                      phase;
  logic [CW-1:0]               byte_count;
  logic [frp_pkg::LEN_W-1:0]   expected_data;
  logic [7:0]                  running_xor;
  logic [7:0]                  addr_low;
  logic [7:0]                  cmd_byte;
  logic                        pending;     // a replay still reads the store

  logic accept;
  logic overflow;
  logic csum_ok;
  logic data_done;
  logic [frp_pkg::LEN_W-1:0] cmd_len;

  // Data bytes wait while the previous frame is still being replayed.
  assign in.ready = !q_full && !((phase == PH_DATA) && pending);
  assign accept   = in.valid && in.ready;

  assign overflow  = (byte_count >= LIMIT);
  assign csum_ok   = (in.rx_byte == running_xor);
  assign data_done = ((byte_count + CW'(1)) == (HDR + CW'(expected_data)));
  assign cmd_len   = frp_pkg::len_for_command(in.rx_byte);

  always_comb begin
    q_job = '{status: frp_pkg::ST_BUSY, addr: '0, cmd: '0, len: '0};
    if (overflow) begin
      q_job.status = frp_pkg::ST_OVFL;
    end else if (phase == PH_CSUM) begin
      if (!csum_ok) begin
        q_job.status = frp_pkg::ST_CSUM;
      end else begin
        q_job.status = frp_pkg::ST_GOOD;
        q_job.addr   = addr_low;
        q_job.cmd    = cmd_byte;
        q_job.len    = expected_data;
      end
    end
  end

  assign q_push        = accept;
  assign store_wr.en   = accept && !overflow && (phase == PH_DATA);
  assign store_wr.addr = frp_pkg::IDX_W'(byte_count - HDR);
  assign store_wr.data = in.rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC;
      byte_count    <= '0;
      expected_data <= '0;
      running_xor   <= '0;
      addr_low      <= '0;
      cmd_byte      <= '0;
      pending       <= 1'b0;
    end else begin
      if (run_done) begin
        pending <= 1'b0;
      end
      if (accept) begin
        if (overflow) begin
          phase      <= PH_SYNC;
          byte_count <= '0;
        end else begin
          case (phase)
            PH_AHI: begin
              running_xor <= running_xor ^ in.rx_byte;
              byte_count  <= byte_count + CW'(1);
              phase       <= PH_ALO;
            end
            PH_ALO: begin
              running_xor <= running_xor ^ in.rx_byte;
              addr_low    <= in.rx_byte;
              byte_count  <= byte_count + CW'(1);
              phase       <= PH_CMD;
            end
            PH_CMD: begin
              running_xor   <= running_xor ^ in.rx_byte;
              cmd_byte      <= in.rx_byte;
              expected_data <= cmd_len;
              byte_count    <= byte_count + CW'(1);
              phase         <= (cmd_len != '0) ? PH_DATA : PH_CSUM;
            end
            PH_DATA: begin
              running_xor <= running_xor ^ in.rx_byte;
              byte_count  <= byte_count + CW'(1);
              if (data_done) begin
                phase <= PH_CSUM;
              end
            end
            PH_CSUM: begin
              phase      <= PH_SYNC;
              byte_count <= '0;
              if (csum_ok && (expected_data != '0)) begin
                pending <= 1'b1;
              end
            end
            default: begin
              if (in.rx_byte == frp_pkg::SYNC_BYTE) begin
                phase       <= PH_AHI;
                byte_count  <= CW'(1);
                running_xor <= '0;
              end
            end
          endcase
        end
      end
    end
  end

  `ASSERT_IMP(a_no_store_clobber, store_wr.en, !pending, "store written during replay")

endmodule

[rtl/frp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_back
// Result engine: turns queued jobs into results, replaying a good frame's
// data bytes from the store one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frp_back (
  input  logic                clk,
  input  logic                rst,
  input  frp_pkg::store_wr_t  store_wr,
  input  logic                q_valid,
  input  frp_pkg::job_t       q_job,
  output logic                q_pop,
  output logic                run_done,
  frp_out_if.source           out
);

  localparam int IW = frp_pkg::IDX_W;
  localparam int LW = frp_pkg::LEN_W;

  typedef enum logic {B_IDLE, B_RUN} state_t;

  state_t          state;
  frp_pkg::job_t   cur;
  logic [IW-1:0]   idx;

  logic [7:0] store [frp_pkg::STORE_DEPTH];

  logic            out_valid;
  logic [1:0]      out_status;
  logic [7:0]      out_addr;
  logic [7:0]      out_cmd;
  logic [LW-1:0]   out_len;
  logic [IW-1:0]   out_index;
  logic [7:0]      out_byte;
  logic            out_last;

  logic out_free;
  logic last_elem;
  logic issue_last;
  logic run_end;

  assign out_free   = !out_valid || out.ready;
  assign q_pop      = (state == B_IDLE) && q_valid && out_free;
  assign last_elem  = (idx == IW'(cur.len - LW'(1)));
  assign issue_last = (state == B_RUN) && out_free && last_elem;
  assign run_end    = run_done && out_last && (state == B_IDLE);

  assign out.valid      = out_valid;
  assign out.status     = out_status;
  assign out.node_addr  = out_addr;
  assign out.command    = out_cmd;
  assign out.data_count = out_len;
  assign out.data_index = out_index;
  assign out.data_byte  = out_byte;
  assign out.last       = out_last;

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store[store_wr.addr] <= store_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      run_done  <= 1'b0;
    end else begin
      run_done <= 1'b0;
      if (out_valid && out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            if ((q_job.status == frp_pkg::ST_GOOD) && (q_job.len != '0)) begin
              cur   <= q_job;
              idx   <= '0;
              state <= B_RUN;
            end else begin
              // status result, or a good frame without data
              out_valid  <= 1'b1;
              out_status <= q_job.status;
              out_addr   <= q_job.addr;
              out_cmd    <= q_job.cmd;
              out_len    <= q_job.len;
              out_index  <= '0;
              out_byte   <= '0;
              out_last   <= 1'b1;
            end
          end
        end
        B_RUN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= frp_pkg::ST_GOOD;
            out_addr   <= cur.addr;
            out_cmd    <= cur.cmd;
            out_len    <= cur.len;
            out_index  <= idx;
            out_byte   <= store[idx];
            out_last   <= last_elem;
            idx        <= idx + IW'(1);
            if (last_elem) begin
              state    <= B_IDLE;
              run_done <= 1'b1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_idx_in_frame, state == B_RUN, idx < IW'(cur.len), "replay index past frame length")
  `ASSERT_NXT(a_done_after_last, issue_last, run_end, "replay end not flagged")

endmodule

[rtl/framed_reply_parser_xor.sv]
// Result path: a status result passes the job queue, then the output register; a good
// frame's first data result passes the queue, the replay state and the output register,
// then one per cycle while the receiver is ready. Throughput: one byte per cycle while
// results drain; a replay issues one result per data byte, the 4-entry job queue lets other
// bytes run ahead, and next-frame data bytes wait for run_done after the last replay result.
// Reset (rst, synchronous): parser back to sync hunt, queue and output emptied.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_reply_parser_xor
// Sync-framed reply parser with XOR checksum: front parser, job queue,
// result back end.
// ----------------------------------------------------------------------------
module framed_reply_parser_xor #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic       clk,
  input  logic       rst,
  frp_in_if.sink     in,
  frp_out_if.source  out
);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  frp_pkg::job_t      q_job_in;
  frp_pkg::job_t      q_job_out;
  frp_pkg::store_wr_t store_wr;
  logic               run_done;

  frp_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in       (in),
    .run_done (run_done),
    .q_push   (q_push),
    .q_job    (q_job_in),
    .q_full   (q_full),
    .store_wr (store_wr)
  );

  frp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (q_job_in),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (q_job_out),
    .not_empty (q_valid)
  );

  frp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .store_wr (store_wr),
    .q_valid  (q_valid),
    .q_job    (q_job_out),
    .q_pop    (q_pop),
    .run_done (run_done),
    .out      (out)
  );

endmodule

[bench/framed_reply_parser_xor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_reply_parser_xor_tb
// Self-checking bench for the sync-framed reply parser. A short table of
// directed bytes is followed by random frames (good, corrupted and broken)
// and line noise. Every accepted byte is run through a local frame parser
// model, and each result item is checked against the oldest expected reply.
// Sender gaps, receiver stalls and one long receiver hold are applied.
// ----------------------------------------------------------------------------
module framed_reply_parser_xor_tb;

  localparam int MAX_FRAME    = 32;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_BYTES  = 12;

  typedef enum logic [2:0] {
    P_HUNT,
    P_ADDR_HI,
    P_ADDR_LO,
    P_CMD,
    P_DATA,
    P_CSUM
  } parse_phase_t;

  typedef struct packed {
    frp_pkg::status_t status;
    logic [7:0]       addr;
    logic [7:0]       cmd;
    logic [4:0]       len;
    logic [4:0]       idx;
    logic [7:0]       data;
    logic             last;
  } reply_t;

  // typed rows carry their expected status; the rest take theirs from the parser model
  typedef struct packed {
    logic [7:0]       rx;
    bit               typed;
    frp_pkg::status_t st;
  } stim_t;

  localparam stim_t DIRECTED [25] = '{
    '{8'h00,              1'b1, frp_pkg::ST_BUSY},  // noise while hunting
    '{frp_pkg::SYNC_BYTE, 1'b1, frp_pkg::ST_BUSY},
    '{8'hFF,              1'b1, frp_pkg::ST_BUSY},
    '{8'h00,              1'b1, frp_pkg::ST_BUSY},
    '{8'h51,              1'b1, frp_pkg::ST_BUSY},  // unknown command, no data
    '{8'h00,              1'b1, frp_pkg::ST_CSUM},  // sum should be AE
    '{frp_pkg::SYNC_BYTE, 1'b0, frp_pkg::ST_BUSY},
    '{8'h12,              1'b0, frp_pkg::ST_BUSY},
    '{8'h34,              1'b0, frp_pkg::ST_BUSY},
    '{8'h00,              1'b0, frp_pkg::ST_BUSY},
    '{8'h26,              1'b0, frp_pkg::ST_BUSY},  // good frame without data
    '{frp_pkg::SYNC_BYTE, 1'b0, frp_pkg::ST_BUSY},
    '{8'h80,              1'b0, frp_pkg::ST_BUSY},
    '{8'h7F,              1'b0, frp_pkg::ST_BUSY},
    '{frp_pkg::CMD_S,     1'b0, frp_pkg::ST_BUSY},
    '{8'hFF,              1'b0, frp_pkg::ST_BUSY},
    '{8'h00,              1'b0, frp_pkg::ST_BUSY},
    '{8'h53,              1'b0, frp_pkg::ST_BUSY},
    '{frp_pkg::SYNC_BYTE, 1'b0, frp_pkg::ST_BUSY},
    '{8'h02,              1'b0, frp_pkg::ST_BUSY},  // in-frame sync value is an address byte
    '{8'hAA,              1'b0, frp_pkg::ST_BUSY},
    '{frp_pkg::CMD_D,     1'b0, frp_pkg::ST_BUSY},
    '{8'h02,              1'b0, frp_pkg::ST_BUSY},
    '{8'h55,              1'b0, frp_pkg::ST_BUSY},
    '{8'hBB,              1'b0, frp_pkg::ST_BUSY}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  frp_in_if  in_if ();
  frp_out_if out_if ();

  framed_reply_parser_xor #(
    .MAX_FRAME(MAX_FRAME)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in (in_if),
    .out(out_if)
  );

  always #4 clk = ~clk;

  // parser model state
  parse_phase_t fr_phase = P_HUNT;
  logic [5:0]   fr_count = '0;
  logic [4:0]   fr_len   = '0;
  logic [7:0]   fr_xor   = '0;
  logic [7:0]   fr_addr  = '0;
  logic [7:0]   fr_cmd   = '0;
  logic [7:0]   fr_data [32];

  reply_t step_replies[$];
  reply_t pending_replies[$];

  int mismatches   = 0;
  int bytes_sent   = 0;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit hold_go      = 1'b0;
  bit hold_seen    = 1'b0;

  function automatic int frame_len(input logic [7:0] c);
    case (c)
      frp_pkg::CMD_S, frp_pkg::CMD_D: return 2;
      frp_pkg::CMD_L, frp_pkg::CMD_R: return 10;
      frp_pkg::CMD_T:                 return 22;
      frp_pkg::CMD_C:                 return 11;
      frp_pkg::CMD_Z:                 return 6;
      default:                        return 0;
    endcase
  endfunction

  // Advance the model by one byte; its replies land in step_replies.
  task automatic parse_byte(input logic [7:0] b);
    reply_t r;
    step_replies.delete();
    r = '0;
    r.status = frp_pkg::ST_BUSY;
    r.last = 1'b1;
    if (fr_count >= 6'(MAX_FRAME)) begin
      fr_phase = P_HUNT;
      fr_count = '0;
      r.status = frp_pkg::ST_OVFL;
    end else begin
      case (fr_phase)
        P_ADDR_HI: begin
          fr_xor ^= b;
          fr_count++;
          fr_phase = P_ADDR_LO;
        end
        P_ADDR_LO: begin
          fr_xor ^= b;
          fr_addr = b;
          fr_count++;
          fr_phase = P_CMD;
        end
        P_CMD: begin
          fr_xor ^= b;
          fr_cmd = b;
          fr_len = 5'(frame_len(b));
          fr_count++;
          fr_phase = (fr_len != 0) ? P_DATA : P_CSUM;
        end
        P_DATA: begin
          fr_xor ^= b;
          fr_data[5'(fr_count - 6'd4)] = b;
          fr_count++;
          if (fr_count == 6'(fr_len) + 6'd4) fr_phase = P_CSUM;
        end
        P_CSUM: begin
          fr_phase = P_HUNT;
          fr_count = '0;
          if (b != fr_xor) begin
            r.status = frp_pkg::ST_CSUM;
          end else begin
            r.status = frp_pkg::ST_GOOD;
            r.addr = fr_addr;
            r.cmd = fr_cmd;
            r.len = fr_len;
          end
        end
        default: begin
          if (b == frp_pkg::SYNC_BYTE) begin
            fr_phase = P_ADDR_HI;
            fr_count = 6'd1;
            fr_xor = '0;
          end
        end
      endcase
    end
    if (r.status == frp_pkg::ST_GOOD && fr_len != 0) begin
      // replay of the data bytes, one item each
      for (int k = 0; k < int'(fr_len); k++) begin
        r.idx = 5'(k);
        r.data = fr_data[k];
        r.last = (k == int'(fr_len) - 1);
        step_replies.push_back(r);
      end
    end else begin
      step_replies.push_back(r);
    end
  endtask

  task automatic send_item(input stim_t s);
    reply_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.rx_byte <= s.rx;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
    parse_byte(s.rx);
    if (s.typed) begin
      r = '0;
      r.status = s.st;
      r.last = 1'b1;
      pending_replies.push_back(r);
    end else begin
      foreach (step_replies[i]) pending_replies.push_back(step_replies[i]);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    stim_t s;
    s = '{b, 1'b0, frp_pkg::ST_BUSY};
    send_item(s);
  endtask

  task automatic send_frame();
    logic [7:0] sum;
    logic [7:0] c;
    logic [7:0] b;
    int n;
    case ($urandom_range(7))
      0:       c = frp_pkg::CMD_S;
      1:       c = frp_pkg::CMD_L;
      2:       c = frp_pkg::CMD_R;
      3:       c = frp_pkg::CMD_T;
      4:       c = frp_pkg::CMD_C;
      5:       c = frp_pkg::CMD_Z;
      6:       c = frp_pkg::CMD_D;
      default: c = 8'($urandom);
    endcase
    n = frame_len(c);
    send_byte(frp_pkg::SYNC_BYTE);
    b = 8'($urandom);
    sum = b;
    send_byte(b);
    b = 8'($urandom);
    sum ^= b;
    send_byte(b);
    sum ^= c;
    send_byte(c);
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom);
      sum ^= b;
      send_byte(b);
    end
    if ($urandom_range(99) < 15) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  task automatic random_traffic(input int n_bytes);
    int target;
    int pick;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_byte(8'($urandom));
      end else if (pick < 18) begin
        // frame cut short, following bytes land in its body
        send_byte(frp_pkg::SYNC_BYTE);
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end else begin
        send_frame();
      end
    end
  endtask

  // result side: check, then decide ready for the next edge
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      got.status = frp_pkg::status_t'(out_if.status);
      got.addr = out_if.node_addr;
      got.cmd = out_if.command;
      got.len = out_if.data_count;
      got.idx = out_if.data_index;
      got.data = out_if.data_byte;
      got.last = out_if.last;
      if (pending_replies.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: st=%0d addr=%h cmd=%h len=%0d idx=%0d data=%h last=%b",
                   got.status, got.addr, got.cmd, got.len, got.idx, got.data, got.last);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("mismatch exp: st=%0d addr=%h cmd=%h len=%0d idx=%0d data=%h last=%b",
                     want.status, want.addr, want.cmd, want.len, want.idx, want.data,
                     want.last);
            $display("         got: st=%0d addr=%h cmd=%h len=%0d idx=%0d data=%h last=%b",
                     got.status, got.addr, got.cmd, got.len, got.idx, got.data, got.last);
          end
          mismatches++;
        end
      end
    end
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_item(DIRECTED[i]);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 46;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 46;
        end
        3: begin
          idle_pct = 7;
          stall_pct <= 7;
        end
        default: begin
          // long receiver hold while bytes keep coming
          idle_pct = 0;
          stall_pct <= 0;
          hold_go <= 1'b1;
        end
      endcase
      random_traffic(PHASE_BYTES);
    end

    in_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[framed_reply_parser_xor.f]
+incdir+rtl
rtl/frp_pkg.sv
rtl/frp_if.sv
rtl/frp_fifo.sv
rtl/frp_front.sv
rtl/frp_back.sv
rtl/framed_reply_parser_xor.sv
bench/framed_reply_parser_xor_tb.sv
